// ----- rtl/lzw_compress_decoder_top_assert.svh -----
// Assertion macros shared by the decoder's top level.
`ifndef LZW_COMPRESS_DECODER_TOP_ASSERT_SVH
`define LZW_COMPRESS_DECODER_TOP_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define LZWD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzwd assertion failed");
// Antecedent implies consequent in the following cycle.
`define LZWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzwd assertion failed");
`endif

// ----- rtl/lzwd_pkg.sv -----
// Types and constants of the LZW (.Z) stream decoder.
package lzwd_pkg;

  localparam int MaxCodeBits = 12;
  localparam int TableDepth  = 1 << MaxCodeBits;
  localparam int StackDepth  = 4096;
  localparam int TabIdxW     = MaxCodeBits;
  localparam int StackIdxW   = $clog2(StackDepth);
  localparam int FillW       = StackIdxW + 1;
  localparam int NfcW        = MaxCodeBits + 1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [7:0] MAGIC0     = 8'h1F;
  localparam logic [7:0] MAGIC1     = 8'h9D;
  localparam logic [8:0] CODE_CLEAR = 9'd256;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PUSH,
    CMD_PULL,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_TAKEN    = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_NEED     = 3'd3,
    ST_BADMAGIC = 3'd4,
    ST_BADWIDTH = 3'd5,
    ST_STARTED  = 3'd6
  } st_e;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_FLAGS,
    PH_FIRST,
    PH_DATA,
    PH_SKIP,
    PH_BADMAGIC,
    PH_BADWIDTH
  } ph_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP,
    BK_CHAIN,
    BK_TREAD,
    BK_FINISH
  } bk_state_e;

endpackage

// ----- rtl/lzwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/lzwd_front.sv -----
// Front end: accepts requests, classifies the opcode and queues the command.
module lzwd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        in_byte_i,
  output logic              q_valid_o,
  output lzwd_pkg::cmd_t    q_head_o,
  input  logic              q_pop_i
);

  lzwd_pkg::cmd_t entry_q [2];
  lzwd_pkg::cmd_t cmd_in;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  // Classify the opcode into a command.
  always_comb begin
    cmd_in.data = in_byte_i;
    unique case (opcode_i)
      lzwd_pkg::OP_START: cmd_in.kind = lzwd_pkg::CMD_START;
      lzwd_pkg::OP_PUSH:  cmd_in.kind = lzwd_pkg::CMD_PUSH;
      lzwd_pkg::OP_PULL:  cmd_in.kind = lzwd_pkg::CMD_PULL;
      default:            cmd_in.kind = lzwd_pkg::CMD_BAD;
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_head_o   = entry_q[rd_ptr_q];

  // Two-entry command queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/lzwd_back.sv -----
// Back end: header parsing, code unpacking, dictionary walk and string stack.
module lzwd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lzwd_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           idle_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic [2:0]     status_o
);

  localparam int TIW = lzwd_pkg::TabIdxW;
  localparam int SIW = lzwd_pkg::StackIdxW;
  localparam int FW  = lzwd_pkg::FillW;
  localparam int NW  = lzwd_pkg::NfcW;

  lzwd_pkg::bk_state_e state_q, state_d;
  lzwd_pkg::ph_e       phase_q, phase_d;
  logic [23:0]    buf_q, buf_d;
  logic [4:0]     held_q, held_d;
  logic [3:0]     gbs_q, gbs_d;
  logic [3:0]     width_q, width_d;
  logic [3:0]     max_q, max_d;
  logic           block_q, block_d;
  logic [NW-1:0]  nfc_q, nfc_d;
  logic [TIW-1:0] prev_q, prev_d;
  logic [7:0]     fc_q, fc_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [TIW-1:0] cur_q, cur_d;
  logic [TIW-1:0] code_q, code_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, out_byte_d;
  lzwd_pkg::st_e  status_q, status_d;

  logic           t_we, s_we;
  logic [TIW-1:0] t_waddr, t_raddr;
  logic [TIW+7:0] t_wdata, t_rdata;
  logic [SIW-1:0] s_waddr, s_raddr;
  logic [7:0]     s_wdata, s_rdata;

  logic           out_free, skip_req;
  logic [23:0]    mask;
  logic [TIW-1:0] code;
  logic [4:0]     flag_w;
  logic [NW-1:0]  nfc_new, limit;

  lzwd_ram #(.Width(TIW + 8), .Depth(lzwd_pkg::TableDepth)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  lzwd_ram #(.Width(8), .Depth(lzwd_pkg::StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign idle_o      = (state_q == lzwd_pkg::BK_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign mask        = (24'd1 << width_q) - 24'd1;
  assign code        = TIW'(buf_q & mask);
  assign flag_w      = q_head_i.data[4:0];
  assign nfc_new     = nfc_q + NW'(1);
  assign limit       = (width_q == max_q) ? (NW'(1) << width_q)
                                          : ((NW'(1) << width_q) - NW'(1));

  // Command sequencer.
  always_comb begin
    state_d = state_q;   phase_d = phase_q;   buf_d = buf_q;
    held_d = held_q;     gbs_d = gbs_q;       width_d = width_q;
    max_d = max_q;       block_d = block_q;   nfc_d = nfc_q;
    prev_d = prev_q;     fc_d = fc_q;         fill_d = fill_q;
    cur_d = cur_q;       code_d = code_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d = out_byte_q;
    status_d = status_q;
    q_pop_o = 1'b0;      skip_req = 1'b0;
    t_we = 1'b0;         t_waddr = nfc_q[TIW-1:0];
    t_wdata = {prev_q, fc_q};
    t_raddr = cur_q;
    s_we = 1'b0;         s_waddr = fill_q[SIW-1:0];
    s_wdata = 8'd0;      s_raddr = SIW'(fill_q - FW'(1));

    unique case (state_q)
      lzwd_pkg::BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d = 8'd0;
          status_d = lzwd_pkg::ST_REFUSED;
          unique case (q_head_i.kind)
            lzwd_pkg::CMD_START: begin
              phase_d = lzwd_pkg::PH_MAGIC0; buf_d = '0; held_d = '0; gbs_d = '0;
              width_d = 4'd9; max_d = 4'd12; block_d = 1'b1; nfc_d = NW'(257);
              prev_d = '0; fc_d = '0; fill_d = '0;
              status_d = lzwd_pkg::ST_STARTED;
            end
            lzwd_pkg::CMD_PUSH: begin
              case (phase_q)
                lzwd_pkg::PH_MAGIC0, lzwd_pkg::PH_MAGIC1: begin
                  if (q_head_i.data == ((phase_q == lzwd_pkg::PH_MAGIC0) ?
                                        lzwd_pkg::MAGIC0 : lzwd_pkg::MAGIC1)) begin
                    phase_d = (phase_q == lzwd_pkg::PH_MAGIC0) ? lzwd_pkg::PH_MAGIC1
                                                               : lzwd_pkg::PH_FLAGS;
                    status_d = lzwd_pkg::ST_TAKEN;
                  end else begin
                    phase_d = lzwd_pkg::PH_BADMAGIC;
                    status_d = lzwd_pkg::ST_BADMAGIC;
                  end
                end
                lzwd_pkg::PH_FLAGS: begin
                  if (flag_w < 5'd9 || flag_w > 5'(lzwd_pkg::MaxCodeBits)) begin
                    phase_d = lzwd_pkg::PH_BADWIDTH;
                    status_d = lzwd_pkg::ST_BADWIDTH;
                  end else begin
                    max_d = flag_w[3:0];
                    block_d = q_head_i.data[7];
                    width_d = 4'd9;
                    nfc_d = q_head_i.data[7] ? NW'(257) : NW'(256);
                    phase_d = lzwd_pkg::PH_FIRST;
                    status_d = lzwd_pkg::ST_TAKEN;
                  end
                end
                lzwd_pkg::PH_FIRST, lzwd_pkg::PH_DATA: begin
                  if (gbs_q >= width_q && held_q != 5'd0) begin
                    status_d = lzwd_pkg::ST_REFUSED;
                  end else if (held_q > 5'd16) begin
                    status_d = lzwd_pkg::ST_REFUSED;
                  end else begin
                    buf_d = buf_q | (24'(q_head_i.data) << held_q);
                    held_d = held_q + 5'd8;
                    gbs_d = ((gbs_q >= width_q) ? 4'd0 : gbs_q) + 4'd1;
                    status_d = lzwd_pkg::ST_TAKEN;
                  end
                end
                lzwd_pkg::PH_SKIP: begin
                  // Bytes that pad out a skipped group are dropped.
                  gbs_d = (gbs_q > 4'd0) ? gbs_q - 4'd1 : gbs_q;
                  if (gbs_d == 4'd0) begin
                    phase_d = lzwd_pkg::PH_DATA;
                  end
                  status_d = lzwd_pkg::ST_TAKEN;
                end
                lzwd_pkg::PH_BADMAGIC: status_d = lzwd_pkg::ST_BADMAGIC;
                default:               status_d = lzwd_pkg::ST_BADWIDTH;
              endcase
            end
            lzwd_pkg::CMD_PULL: begin
              if (phase_q == lzwd_pkg::PH_BADMAGIC) begin
                status_d = lzwd_pkg::ST_BADMAGIC;
              end else if (phase_q == lzwd_pkg::PH_BADWIDTH) begin
                status_d = lzwd_pkg::ST_BADWIDTH;
              end else if (fill_q != '0) begin
                // Pending string byte: read the stack top, deliver it from the pop state.
                out_valid_d = 1'b0;
                fill_d = fill_q - FW'(1);
                state_d = lzwd_pkg::BK_POP;
              end else if ((phase_q != lzwd_pkg::PH_FIRST && phase_q != lzwd_pkg::PH_DATA)
                           || held_q < 5'(width_q)) begin
                status_d = lzwd_pkg::ST_NEED;
              end else begin
                buf_d = buf_q >> width_q;
                held_d = held_q - 5'(width_q);
                if (phase_q == lzwd_pkg::PH_FIRST) begin
                  fc_d = code[7:0];
                  prev_d = code;
                  phase_d = lzwd_pkg::PH_DATA;
                  out_byte_d = code[7:0];
                  status_d = lzwd_pkg::ST_BYTE;
                end else if (block_q && code == TIW'(lzwd_pkg::CODE_CLEAR)) begin
                  nfc_d = NW'(256);
                  width_d = 4'd9;
                  skip_req = 1'b1;
                  status_d = lzwd_pkg::ST_NEED;
                end else begin
                  // Start the dictionary walk; the special case of a code not yet
                  // in the table repeats the previous string's first byte.
                  out_valid_d = 1'b0;
                  code_d = code;
                  state_d = lzwd_pkg::BK_CHAIN;
                  if (NW'(code) >= nfc_q) begin
                    s_we = 1'b1;
                    s_waddr = '0;
                    s_wdata = fc_q;
                    fill_d = FW'(1);
                    cur_d = prev_q;
                  end else begin
                    fill_d = '0;
                    cur_d = code;
                  end
                end
              end
            end
            default: status_d = lzwd_pkg::ST_REFUSED;
          endcase
        end
      end
      lzwd_pkg::BK_POP: begin
        out_valid_d = 1'b1;
        out_byte_d = s_rdata;
        status_d = lzwd_pkg::ST_BYTE;
        state_d = lzwd_pkg::BK_IDLE;
      end
      lzwd_pkg::BK_CHAIN: begin
        if (cur_q >= TIW'(256)) begin
          state_d = lzwd_pkg::BK_TREAD;
        end else begin
          fc_d = cur_q[7:0];
          state_d = lzwd_pkg::BK_FINISH;
        end
      end
      lzwd_pkg::BK_TREAD: begin
        if (fill_q < FW'(lzwd_pkg::StackDepth - 1)) begin
          s_we = 1'b1;
          s_wdata = t_rdata[7:0];
          fill_d = fill_q + FW'(1);
          cur_d = t_rdata[TIW+7:8];
          state_d = lzwd_pkg::BK_CHAIN;
        end else begin
          fc_d = t_rdata[7:0];
          state_d = lzwd_pkg::BK_FINISH;
        end
      end
      lzwd_pkg::BK_FINISH: begin
        // The first byte is pushed and popped at once, so it goes straight out.
        if (nfc_q < (NW'(1) << max_q)) begin
          t_we = 1'b1;
          nfc_d = nfc_new;
        end
        prev_d = code_q;
        if (nfc_d > limit) begin
          width_d = width_q + 4'd1;
          skip_req = 1'b1;
        end
        out_valid_d = 1'b1;
        out_byte_d = fc_q;
        status_d = lzwd_pkg::ST_BYTE;
        state_d = lzwd_pkg::BK_IDLE;
      end
      default: state_d = lzwd_pkg::BK_IDLE;
    endcase

    // Drop the rest of the current code group.
    if (skip_req) begin
      buf_d = '0;
      held_d = '0;
      if (gbs_q < width_q) begin
        gbs_d = width_q - gbs_q;
        phase_d = lzwd_pkg::PH_SKIP;
      end else begin
        gbs_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzwd_pkg::BK_IDLE;  phase_q <= lzwd_pkg::PH_MAGIC0;
      buf_q <= '0;    held_q <= '0;   gbs_q <= '0;
      width_q <= 4'd9; max_q <= 4'd12; block_q <= 1'b1;
      nfc_q <= NW'(257); prev_q <= '0; fc_q <= '0; fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  phase_q <= phase_d;
      buf_q <= buf_d;      held_q <= held_d;   gbs_q <= gbs_d;
      width_q <= width_d;  max_q <= max_d;     block_q <= block_d;
      nfc_q <= nfc_d;      prev_q <= prev_d;   fc_q <= fc_d;  fill_q <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    code_q <= code_d;
    out_byte_q <= out_byte_d;
    status_q <= status_d;
  end

endmodule

// ----- rtl/lzw_compress_decoder_top.sv -----
// Top level of the Unix compress (.Z) stream decoder.
// Each request (start, push a compressed byte, pull a decoded byte) yields one
// result with a status. Start and push are answered from the idle state; a pull
// that pops a pending string byte reads the stack RAM through the pop state; a
// pull that decodes a new code walks its dictionary chain through the chain and
// table-read states, one registered read of the table RAM per link. A two-entry
// command queue keeps requests flowing while a result waits to be taken.
module lzw_compress_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o
);

  logic           q_valid, q_pop, back_idle;
  lzwd_pkg::cmd_t q_head;

  lzwd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .in_byte_i,
    .q_valid_o(q_valid), .q_head_o(q_head), .q_pop_i(q_pop)
  );

  lzwd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_head_i(q_head), .q_pop_o(q_pop),
    .idle_o(back_idle), .out_valid_o, .out_stall_i, .out_byte_o, .status_o
  );

`include "lzw_compress_decoder_top_assert.svh"

  // A result byte is zero unless the status reports a byte.
  `LZWD_ASSERT_IMP(a_byte_zero, out_valid_o && status_o != 3'(lzwd_pkg::ST_BYTE), out_byte_o == 8'd0)
  // No result appears without a queued command.
  `LZWD_ASSERT_NEXT(a_no_spurious, !q_valid && back_idle && !out_valid_o, !out_valid_o)

endmodule

// ----- test/lzwd_checker.sv -----
// Checker for the .Z stream decoder: predicts each result and compares it in order.
module lzwd_checker
  import lzwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [2:0] status_i,
  input  logic       end_i,
  output int         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    st_e        st;
  } outcome_t;

  // Results still owed by the decoder, oldest first.
  outcome_t owed_q[$];

  // Predicted decoder state.
  logic [11:0] pfx_tab [TableDepth];
  logic [7:0]  sfx_tab [TableDepth];
  logic [7:0]  str_stack [StackDepth];
  int unsigned fill, nfc, prev_code, width, max_width, bit_buf, held, grp_seen;
  logic [7:0]  first_ch;
  bit          blk;
  ph_e         ph;

  int errors = 0;
  bit leftover_checked = 0;

  assign fail_count_o = errors;

  task automatic report(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic void restart();
    fill      = 0;
    nfc       = 257;
    prev_code = 0;
    first_ch  = 8'h00;
    width     = 9;
    max_width = 12;
    blk       = 1'b1;
    bit_buf   = 0;
    held      = 0;
    grp_seen  = 0;
    ph        = PH_MAGIC0;
  endfunction

  function automatic int unsigned limit_of(input int unsigned w);
    return (w == max_width) ? (1 << w) : ((1 << w) - 1);
  endfunction

  // Discard the rest of a code group after a width change or a clear.
  function automatic void drop_group(input int unsigned old_w);
    bit_buf = 0;
    held    = 0;
    if (grp_seen < old_w) begin
      grp_seen = old_w - grp_seen;
      ph       = PH_SKIP;
    end else begin
      grp_seen = 0;
    end
  endfunction

  function automatic void stack_in(input logic [7:0] b);
    if (fill < StackDepth) begin
      str_stack[fill] = b;
      fill++;
    end
  endfunction

  // Expands one code onto the stack; returns 0 when the code was a clear.
  function automatic bit expand_code(input int unsigned c);
    int unsigned cur;
    int unsigned old_w;
    cur   = c;
    old_w = width;
    if (blk && c == CODE_CLEAR) begin
      nfc   = 256;
      width = 9;
      drop_group(old_w);
      return 1'b0;
    end
    fill = 0;
    // The code not yet in the table: the previous string plus its own first byte.
    if (cur >= nfc) begin
      stack_in(first_ch);
      cur = prev_code;
    end
    while (cur >= 256 && fill < StackDepth - 1) begin
      stack_in(sfx_tab[cur % TableDepth]);
      cur = pfx_tab[cur % TableDepth];
    end
    first_ch = sfx_tab[cur % TableDepth];
    stack_in(first_ch);
    if (nfc < (1 << max_width)) begin
      pfx_tab[nfc % TableDepth] = prev_code[11:0];
      sfx_tab[nfc % TableDepth] = first_ch;
      nfc++;
    end
    prev_code = c % TableDepth;
    if (nfc > limit_of(width)) begin
      width++;
      drop_group(old_w);
    end
    return 1'b1;
  endfunction

  function automatic st_e push_step(input int unsigned b);
    case (ph)
      PH_MAGIC0: begin
        ph = (b == MAGIC0) ? PH_MAGIC1 : PH_BADMAGIC;
        return (b == MAGIC0) ? ST_TAKEN : ST_BADMAGIC;
      end
      PH_MAGIC1: begin
        ph = (b == MAGIC1) ? PH_FLAGS : PH_BADMAGIC;
        return (b == MAGIC1) ? ST_TAKEN : ST_BADMAGIC;
      end
      PH_FLAGS: begin
        if ((b & 'h1F) < 9 || (b & 'h1F) > MaxCodeBits) begin
          ph = PH_BADWIDTH;
          return ST_BADWIDTH;
        end
        max_width = b & 'h1F;
        blk       = b[7];
        for (int i = 0; i < 256; i++) begin
          pfx_tab[i] = '0;
          sfx_tab[i] = i[7:0];
        end
        width = 9;
        nfc   = blk ? 257 : 256;
        ph    = PH_FIRST;
        return ST_TAKEN;
      end
      PH_FIRST, PH_DATA: begin
        if (grp_seen >= width) begin
          if (held != 0) return ST_REFUSED;
          grp_seen = 0;
        end
        if (held > 16) return ST_REFUSED;
        bit_buf = (bit_buf | (b << held)) & 'hFFFFFF;
        held += 8;
        grp_seen++;
        return ST_TAKEN;
      end
      PH_SKIP: begin
        if (grp_seen > 0) grp_seen--;
        if (grp_seen == 0) ph = PH_DATA;
        return ST_TAKEN;
      end
      PH_BADMAGIC: return ST_BADMAGIC;
      default: return ST_BADWIDTH;
    endcase
  endfunction

  function automatic st_e pull_step(output logic [7:0] ob);
    int unsigned c;
    ob = 8'h00;
    if (ph == PH_BADMAGIC) return ST_BADMAGIC;
    if (ph == PH_BADWIDTH) return ST_BADWIDTH;
    // A pending string byte goes out before any new code is read.
    if (fill > 0) begin
      fill--;
      ob = str_stack[fill];
      return ST_BYTE;
    end
    if ((ph != PH_FIRST && ph != PH_DATA) || held < width) return ST_NEED;
    c       = bit_buf & ((1 << width) - 1);
    bit_buf = (bit_buf >> width) & 'hFFFFFF;
    held   -= width;
    if (ph == PH_FIRST) begin
      first_ch  = c[7:0];
      prev_code = c % TableDepth;
      ph        = PH_DATA;
      ob        = first_ch;
      return ST_BYTE;
    end
    if (!expand_code(c)) return ST_NEED;
    fill--;
    ob = str_stack[fill];
    return ST_BYTE;
  endfunction

  function automatic outcome_t predict_result(input logic [1:0] op, input logic [7:0] b);
    outcome_t   res;
    logic [7:0] ob;
    ob = 8'h00;
    case (op)
      OP_START: begin
        restart();
        res.st = ST_STARTED;
      end
      OP_PUSH: res.st = push_step(b);
      OP_PULL: res.st = pull_step(ob);
      default: res.st = ST_REFUSED;
    endcase
    res.data = (res.st == ST_BYTE) ? ob : 8'h00;
    return res;
  endfunction

  // Watch both channels: compare each result transfer, then predict each request transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        pfx_tab[i] = '0;
        sfx_tab[i] = '0;
      end
      for (int i = 0; i < StackDepth; i++) str_stack[i] = '0;
      restart();
      owed_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          report($sformatf("result status %0d byte %02h with none owed", status_i, out_byte_i));
        end else begin
          exp_res = owed_q.pop_front();
          if (status_i !== exp_res.st)
            report($sformatf("status %0d, expected %0d", status_i, exp_res.st));
          if (out_byte_i !== exp_res.data)
            report($sformatf("byte %02h, expected %02h", out_byte_i, exp_res.data));
        end
      end
      if (in_valid_i && !in_stall_i) owed_q.push_back(predict_result(opcode_i, in_byte_i));
      if (end_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (owed_q.size() != 0)
          report($sformatf("%0d results never delivered", owed_q.size()));
      end
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives .Z streams and noise into the decoder and gives the verdict.
module tb;
  import lzwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3_000_000;
  localparam int ItemTarget = 1100;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [1:0] opcode    = OP_START;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       end_flag  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] status;
  int         fail_count;

  int  cycles     = 0;
  int  stall_mode = 0;
  int  burst_left = 0;
  int  items_sent = 0;
  st_e last_st;

  // Stream encoder state, mirroring how the decoder will grow its table.
  logic [7:0]      z_bytes[$];
  logic [7:0]      grp[$];
  longint unsigned acc;
  int unsigned     nb, gcount, enc_nfc, enc_w, enc_max, enc_hw, enc_clears;
  int unsigned     committed_hw = 256;
  bit              enc_blk, enc_first;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lzw_compress_decoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .opcode_i   (opcode),
    .in_byte_i  (in_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .status_o   (status)
  );

  lzwd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .opcode_i    (opcode),
    .in_byte_i   (in_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_byte_i  (out_byte),
    .status_i    (status),
    .end_i       (end_flag),
    .fail_count_o(fail_count)
  );

  // Receiver stall pattern, one of four modes redrawn at random periodically; also the watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycles % 5) < 2);
    endcase
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request transfer, then wait for its result transfer (stimulus depends on it).
  task automatic transact(input logic [1:0] op, input logic [7:0] b);
    bit stalled;
    bit got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
    in_valid <= 1'b1;
    opcode   <= op;
    in_byte  <= b;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    in_valid <= 1'b0;
    do begin
      @(negedge clk_i);
      got = out_valid && !out_stall;
      if (got) last_st = st_e'(status);
      @(posedge clk_i);
    end while (!got);
    items_sent++;
  endtask

  // Choose a code that only reaches table entries already written.
  function automatic int unsigned pick_code();
    int unsigned r, top, lo, hi, safe;
    r   = $urandom_range(0, 99);
    top = (enc_nfc < (1 << enc_w)) ? enc_nfc : (1 << enc_w) - 1;
    lo  = enc_blk ? 257 : 256;
    if (enc_first) return $urandom_range(0, 255);
    if (enc_blk && r < 3) return CODE_CLEAR;
    if (r < 70) return $urandom_range(0, 255);
    if (r < 95 && top >= lo) return $urandom_range(lo, top);
    safe = (enc_hw > committed_hw) ? enc_hw : committed_hw;
    hi   = (safe - 1 < (1 << enc_w) - 1) ? safe - 1 : (1 << enc_w) - 1;
    if (hi > enc_nfc) return $urandom_range(enc_nfc + 1, hi);
    return $urandom_range(0, 255);
  endfunction

  // Pack one code LSB first; close the group when full, or pad it on a width change or clear.
  function automatic void emit_code(input int unsigned c);
    int unsigned old_w;
    bit          boundary;
    old_w    = enc_w;
    boundary = 1'b0;
    acc |= longint'(c) << nb;
    nb  += old_w;
    while (nb >= 8) begin
      grp.push_back(acc[7:0]);
      acc >>= 8;
      nb   -= 8;
    end
    gcount++;
    if (enc_first) begin
      enc_first = 1'b0;
    end else if (enc_blk && c == CODE_CLEAR) begin
      enc_nfc = 256;
      enc_w   = 9;
      enc_clears++;
      boundary = 1'b1;
    end else begin
      if (enc_nfc < (1 << enc_max)) enc_nfc++;
      if (enc_nfc > enc_hw) enc_hw = enc_nfc;
      if (enc_nfc > ((enc_w == enc_max) ? (1 << enc_w) : (1 << enc_w) - 1)) begin
        enc_w++;
        boundary = 1'b1;
      end
    end
    if (boundary || gcount == 8) begin
      if (nb > 0) grp.push_back(acc[7:0]);
      acc = 0;
      nb  = 0;
      while (grp.size() < old_w) grp.push_back(8'($urandom));
      foreach (grp[i]) z_bytes.push_back(grp[i]);
      grp.delete();
      gcount = 0;
    end
  endfunction

  // Send a whole stream (header plus codes), draining decoded bytes on the way.
  task automatic run_stream(input logic [7:0] flags, input int ncodes, input bit abandon);
    int idx;
    int needs;
    int cut;
    z_bytes.delete();
    grp.delete();
    z_bytes.push_back(MAGIC0);
    z_bytes.push_back(MAGIC1);
    z_bytes.push_back(flags);
    enc_max    = flags & 'h1F;
    enc_blk    = flags[7];
    enc_nfc    = enc_blk ? 257 : 256;
    enc_w      = 9;
    enc_first  = 1'b1;
    enc_hw     = 256;
    enc_clears = 0;
    acc        = 0;
    nb         = 0;
    gcount     = 0;
    repeat (ncodes) emit_code(pick_code());
    if (nb > 0) grp.push_back(acc[7:0]);
    foreach (grp[i]) z_bytes.push_back(grp[i]);
    cut = $urandom_range(1, z_bytes.size());
    transact(OP_START, 8'($urandom));
    idx = 0;
    while (idx < z_bytes.size()) begin
      if (abandon && idx >= cut) return;
      if ($urandom_range(0, 3) == 0) transact(OP_PULL, 8'($urandom));
      transact(OP_PUSH, z_bytes[idx]);
      if (last_st == ST_TAKEN) idx++;
      else transact(OP_PULL, 8'($urandom));
    end
    // A clear also answers need input, so wait for one more than the clears sent.
    needs = 0;
    while (needs <= enc_clears) begin
      transact(OP_PULL, 8'($urandom));
      if (last_st == ST_NEED) needs++;
    end
    if (enc_hw > committed_hw) committed_hw = enc_hw;
  endtask

  function automatic logic [7:0] rand_flags();
    return {($urandom_range(0, 4) != 0), 2'($urandom), 5'($urandom_range(9, 12))};
  endfunction

  // Stimulus and verdict.
  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pull before data, unused opcode, bad magic, bad widths at both ends.
    transact(OP_START, 8'h00);
    transact(OP_PULL, 8'hFF);
    transact(2'd3, 8'hA5);
    transact(OP_PUSH, 8'h00);
    transact(OP_PULL, 8'h00);
    transact(OP_PUSH, MAGIC0);
    transact(OP_START, 8'hFF);
    transact(OP_PUSH, MAGIC0);
    transact(OP_PUSH, 8'h1E);
    transact(OP_PUSH, 8'hFF);
    transact(OP_START, 8'h00);
    transact(OP_PUSH, MAGIC0);
    transact(OP_PUSH, MAGIC1);
    transact(OP_PUSH, 8'h08);
    transact(OP_PULL, 8'h00);
    transact(OP_START, 8'h00);
    transact(OP_PUSH, MAGIC0);
    transact(OP_PUSH, MAGIC1);
    transact(OP_PUSH, 8'hFF);
    transact(OP_PUSH, 8'h00);
    transact(OP_START, 8'h00);
    transact(OP_PUSH, MAGIC0);
    transact(OP_PUSH, MAGIC1);
    transact(OP_PUSH, 8'h89);
    transact(OP_PULL, 8'h00);

    // One long stream that grows the code width, then a random mix.
    run_stream(8'h8B, 290, 1'b0);
    run_stream(8'h09, 12, 1'b0);
    while (items_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        run_stream(rand_flags(), $urandom_range(1, 40), 1'b0);
      end else if (r < 80) begin
        run_stream(rand_flags(), $urandom_range(4, 40), 1'b1);
      end else if (r < 86) begin
        transact(OP_START, 8'h00);
        if ($urandom_range(0, 1)) transact(OP_PUSH, MAGIC0);
        transact(OP_PUSH, 8'($urandom_range(0, 'h1E)));
        repeat ($urandom_range(1, 4)) transact($urandom_range(0, 1) ? OP_PUSH : OP_PULL,
                                               8'($urandom));
      end else if (r < 92) begin
        transact(OP_START, 8'h00);
        transact(OP_PUSH, MAGIC0);
        transact(OP_PUSH, MAGIC1);
        transact(OP_PUSH, $urandom_range(0, 1) ? 8'($urandom_range(0, 8) | ($urandom & 'hE0))
                                               : 8'($urandom_range(13, 31) | ($urandom & 'hE0)));
        repeat ($urandom_range(1, 4)) transact($urandom_range(0, 1) ? OP_PUSH : OP_PULL,
                                               8'($urandom));
      end else if (r < 97) begin
        // Noise that cannot leave the magic check: pulls, unused opcode, restarts.
        transact(OP_START, 8'($urandom));
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 2))
            0: transact(OP_PULL, 8'($urandom));
            1: transact(2'd3, 8'($urandom));
            default: transact(OP_START, 8'($urandom));
          endcase
        end
      end else begin
        run_stream({1'b1, 2'b00, 5'($urandom_range(10, 12))}, $urandom_range(260, 280), 1'b0);
      end
    end

    end_flag <= 1'b1;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- lzw_compress_decoder_top.f -----
+incdir+rtl
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzwd_front.sv
rtl/lzwd_back.sv
rtl/lzw_compress_decoder_top.sv
test/lzwd_checker.sv
test/tb.sv
